[src/azimuth_histogram_with_bin_offsets_assert.svh]
// Assertion macros for the azimuth histogram block.
// Used by the top level only; no other dependencies.
`ifndef AZIMUTH_HISTOGRAM_WITH_BIN_OFFSETS_ASSERT_SVH
`define AZIMUTH_HISTOGRAM_WITH_BIN_OFFSETS_ASSERT_SVH

// same-cycle implication
`define AZH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AZH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/azh_pkg.sv]
// Shared types and constants for the azimuth histogram block.
// No dependencies.
`timescale 1ns / 1ps

package azh_pkg;

	localparam int FULL_TURN = 92160;
	localparam int HALF_TURN = 46080;

	localparam int ANG_W      = 17;
	localparam int POL_W      = 18;
	localparam int OFS_W      = 17;
	localparam int COUNT_W    = 32;
	localparam int SUM_W      = 48;
	localparam int MASK_W     = 8;
	localparam int HIST_W     = 4;
	localparam int RBIN_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_POLAR_MIN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLAR_MAX      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_ORIGIN = 2'd2;

	localparam logic signed [POL_W-1:0] POLAR_MIN_RST = -18'sd256;
	localparam logic signed [POL_W-1:0] POLAR_MAX_RST = 18'sd46336;
	localparam logic signed [ANG_W-1:0] ORIGIN_RST    = 17'sd0;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic signed [POL_W-1:0] polar_min;
		logic signed [POL_W-1:0] polar_max;
		logic signed [ANG_W-1:0] azimuth_origin;
	} cfg_t;

	typedef struct packed {
		logic        [COUNT_W-1:0] count;
		logic signed [SUM_W-1:0]   sum;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BIN,
		ST_FETCH,
		ST_MODIFY
	} state_t;

endpackage

[src/azh_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module azh_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/azh_acc.sv]
// Saturating update of one histogram entry: count plus one, sum plus offset.
// Depends on azh_pkg.
`timescale 1ns / 1ps

module azh_acc (
	input  azh_pkg::entry_t                    cur,
	input  logic signed [azh_pkg::OFS_W-1:0]   delta,
	output azh_pkg::entry_t                    nxt
);

	logic signed [azh_pkg::SUM_W:0] sum_wide;

	always_comb begin
		sum_wide = (azh_pkg::SUM_W+1)'(cur.sum) + (azh_pkg::SUM_W+1)'(delta);
		nxt.count = (cur.count == '1) ? cur.count : cur.count + 32'd1;
		if (sum_wide[azh_pkg::SUM_W] != sum_wide[azh_pkg::SUM_W-1]) begin
			nxt.sum = sum_wide[azh_pkg::SUM_W] ? azh_pkg::SUM_MIN : azh_pkg::SUM_MAX;
		end else begin
			nxt.sum = sum_wide[azh_pkg::SUM_W-1:0];
		end
	end

endmodule

[src/azh_binner.sv]
// Seven-stage event binner: polar cut, azimuth wrap, bin index and bin-center offset.
// Divisions by constants use reciprocal multiplies with one correction step.
// Depends on azh_pkg.
`timescale 1ns / 1ps

module azh_binner #(
	parameter int NUM_BINS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                event_ok,
	input  logic signed [azh_pkg::ANG_W-1:0]    polar_angle,
	input  logic signed [azh_pkg::ANG_W-1:0]    azimuth_angle,
	input  azh_pkg::cfg_t                       cfg,
	output logic                                done,
	output logic                                pass,
	output logic signed [azh_pkg::ANG_W-1:0]    wrapped_azimuth,
	output logic [$clog2(NUM_BINS)-1:0]         bin,
	output logic signed [azh_pkg::OFS_W-1:0]    delta
);

	localparam int FT  = azh_pkg::FULL_TURN;
	localparam int AW  = $clog2(NUM_BINS);
	localparam int XW  = $clog2(FT * NUM_BINS);
	localparam int RW  = $clog2(2 * FT);
	localparam int MW  = azh_pkg::ANG_W;
	localparam int SB  = XW + 18;
	localparam int RBW = XW + 2;
	localparam longint unsigned RB = (64'd1 << SB) / 64'(FT);
	localparam logic [RBW-1:0] RB_L = RBW'(RB);
	localparam int D   = 2 * NUM_BINS;
	localparam int K   = (FT + D - 1) / D;
	localparam int C   = NUM_BINS + K * D - FT;
	localparam int VW  = $clog2(2 * FT + 3 * NUM_BINS);
	localparam int SD  = VW + 1;
	localparam int RDW = SD - 1;
	localparam longint unsigned RD = (64'd1 << SD) / 64'(D);
	localparam logic [RDW-1:0] RD_L = RDW'(RD);

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic                   pass_s1, pass_s2, pass_s3, pass_s4, pass_s5, pass_s6, pass_s7;
	logic [MW-1:0]          m_s1, m_s2, m_s3, m_s4, m_s5, m_s6, m_s7;
	logic [XW-1:0]          x_s2, x_s3;
	logic [AW-1:0]          q_s3, q_s4, b_s5, b_s6, b_s7;
	logic [RW-1:0]          r_s4;
	logic [VW-1:0]          v_s5, v_s6, dq_s6;
	logic signed [azh_pkg::OFS_W-1:0] delta_s7;

	logic signed [azh_pkg::POL_W-1:0] polar_ext;
	logic signed [azh_pkg::POL_W-1:0] diff;
	logic signed [azh_pkg::POL_W:0]   shifted;
	logic [MW-1:0]                    m_c;
	logic                             pass_c;
	logic [XW+RBW-1:0]                prod_b;
	logic                             rcorr;
	logic [MW-1:0]                    r_c;
	logic [VW+SD-1:0]                 prod_d;
	logic [VW-1:0]                    rem_c;
	logic signed [VW:0]               delta_c;
	logic signed [azh_pkg::POL_W-1:0] wrap_c;

	always_comb begin
		polar_ext = azh_pkg::POL_W'(polar_angle);
		diff = azh_pkg::POL_W'(azimuth_angle) - azh_pkg::POL_W'(cfg.azimuth_origin);
		shifted = (azh_pkg::POL_W+1)'(diff) + (azh_pkg::POL_W+1)'(azh_pkg::HALF_TURN);
		if (shifted < 0) begin
			m_c = MW'(shifted + (azh_pkg::POL_W+1)'(FT));
		end else if (shifted >= (azh_pkg::POL_W+1)'(FT)) begin
			m_c = MW'(shifted - (azh_pkg::POL_W+1)'(FT));
		end else begin
			m_c = MW'(shifted);
		end
		pass_c = event_ok && (polar_ext >= cfg.polar_min) && (polar_ext <= cfg.polar_max);

		prod_b = (XW+RBW)'(x_s2) * (XW+RBW)'(RB_L);

		rcorr = r_s4 >= RW'(FT);
		r_c = rcorr ? MW'(r_s4 - RW'(FT)) : MW'(r_s4);

		prod_d = (VW+SD)'(v_s5) * (VW+SD)'(RD_L);

		rem_c = v_s6 - VW'(dq_s6 * D);
		delta_c = (VW+1)'(dq_s6) + (VW+1)'(rem_c >= VW'(D)) - (VW+1)'(K);

		wrap_c = $signed({1'b0, m_s7}) - azh_pkg::POL_W'(azh_pkg::HALF_TURN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pass_s1 <= pass_c;
			m_s1 <= m_c;
		end
		if (vld_s1) begin
			pass_s2 <= pass_s1;
			m_s2 <= m_s1;
			x_s2 <= XW'(m_s1 * NUM_BINS);
		end
		if (vld_s2) begin
			pass_s3 <= pass_s2;
			m_s3 <= m_s2;
			x_s3 <= x_s2;
			q_s3 <= AW'(prod_b >> SB);
		end
		if (vld_s3) begin
			pass_s4 <= pass_s3;
			m_s4 <= m_s3;
			q_s4 <= q_s3;
			r_s4 <= RW'(x_s3 - XW'(q_s3 * FT));
		end
		if (vld_s4) begin
			pass_s5 <= pass_s4;
			m_s5 <= m_s4;
			b_s5 <= q_s4 + AW'(rcorr);
			v_s5 <= VW'({r_c, 1'b0}) + VW'(C);
		end
		if (vld_s5) begin
			pass_s6 <= pass_s5;
			m_s6 <= m_s5;
			b_s6 <= b_s5;
			v_s6 <= v_s5;
			dq_s6 <= VW'(prod_d >> SD);
		end
		if (vld_s6) begin
			pass_s7 <= pass_s6;
			m_s7 <= m_s6;
			b_s7 <= b_s6;
			delta_s7 <= azh_pkg::OFS_W'(delta_c);
		end
	end

	assign done = vld_s7;
	assign pass = pass_s7;
	assign wrapped_azimuth = wrap_c[azh_pkg::ANG_W-1:0];
	assign bin = b_s7;
	assign delta = delta_s7;

endmodule

[src/azimuth_histogram_with_bin_offsets.sv]
// Azimuth histogram with bin offsets: one bank per histogram, read-modify-write.
// Event: binned in azh_binner, then one RAM read and one update; a rejected event skips the read.
// A new item is taken only in idle, after the previous result has gone to the output register.
// Reset: async, active low; then a clearing pass over all NUM_BINS addresses zeroes all banks
// in parallel while in_ready is low. Config writes are taken at any time.
// Depends on azh_pkg, azh_ram, azh_acc, azh_binner and the assertion header.
`timescale 1ns / 1ps
`include "azimuth_histogram_with_bin_offsets_assert.svh"

module azimuth_histogram_with_bin_offsets #(
	parameter int NUM_BINS     = 64,
	parameter int NUM_PATTERNS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [azh_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [azh_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic                                  event_ok,
	input  logic signed [azh_pkg::ANG_W-1:0]      polar_angle,
	input  logic signed [azh_pkg::ANG_W-1:0]      azimuth_angle,
	input  logic [azh_pkg::MASK_W-1:0]            pattern_mask,
	input  logic [azh_pkg::HIST_W-1:0]            read_histogram,
	input  logic [azh_pkg::RBIN_W-1:0]            read_bin,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  accepted,
	output logic signed [azh_pkg::ANG_W-1:0]      wrapped_azimuth,
	output logic [azh_pkg::RBIN_W-1:0]            bin_index,
	output logic [azh_pkg::COUNT_W-1:0]           bin_count,
	output logic signed [azh_pkg::SUM_W-1:0]      offset_sum
);

	localparam int AW        = $clog2(NUM_BINS);
	localparam int NUM_HISTS = NUM_PATTERNS + 1;
	localparam int EW        = $bits(azh_pkg::entry_t);

	azh_pkg::state_t state_q, state_d;
	azh_pkg::cfg_t   cfg_q;

	logic [AW-1:0] clr_cnt_q;
	logic          clr_last;
	logic          in_xfer;
	logic          bin_start;
	logic          rd_en;
	logic          commit;
	logic          slot_free;
	logic          clearing;

	logic                               op_q;
	logic [azh_pkg::MASK_W-1:0]         mask_q;
	logic [azh_pkg::HIST_W-1:0]         rh_q;
	logic [azh_pkg::RBIN_W-1:0]         rb_q;
	logic                               rd_ok_q;
	logic [AW-1:0]                      addr_q;
	logic                               pass_q;
	logic signed [azh_pkg::ANG_W-1:0]   wrap_q;
	logic signed [azh_pkg::OFS_W-1:0]   delta_q;

	logic                               bin_done;
	logic                               bin_pass;
	logic signed [azh_pkg::ANG_W-1:0]   bin_wrap;
	logic [AW-1:0]                      bin_idx;
	logic signed [azh_pkg::OFS_W-1:0]   bin_delta;

	logic                               out_valid_q;
	logic                               accepted_q;
	logic signed [azh_pkg::ANG_W-1:0]   wrap_out_q;
	logic [azh_pkg::RBIN_W-1:0]         bin_index_q;
	logic [azh_pkg::COUNT_W-1:0]        bin_count_q;
	logic signed [azh_pkg::SUM_W-1:0]   offset_sum_q;

	azh_pkg::entry_t rdata [NUM_HISTS];
	azh_pkg::entry_t upd   [NUM_HISTS];
	azh_pkg::entry_t sel;
	logic [NUM_HISTS-1:0] bank_en;
	logic [AW-1:0]        waddr;

	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign clearing  = state_q == azh_pkg::ST_CLEAR;
	assign clr_last  = clr_cnt_q == AW'(NUM_BINS - 1);
	assign waddr     = clearing ? clr_cnt_q : addr_q;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		bin_start = 1'b0;
		rd_en = 1'b0;
		commit = 1'b0;
		case (state_q)
			azh_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = azh_pkg::ST_IDLE;
				end
			end
			azh_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == azh_pkg::OP_READ) begin
						state_d = azh_pkg::ST_FETCH;
					end else begin
						bin_start = 1'b1;
						state_d = azh_pkg::ST_BIN;
					end
				end
			end
			azh_pkg::ST_BIN: begin
				if (bin_done) begin
					state_d = bin_pass ? azh_pkg::ST_FETCH : azh_pkg::ST_MODIFY;
				end
			end
			azh_pkg::ST_FETCH: begin
				rd_en = 1'b1;
				state_d = azh_pkg::ST_MODIFY;
			end
			azh_pkg::ST_MODIFY: begin
				if (slot_free) begin
					commit = 1'b1;
					state_d = azh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = azh_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= azh_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
			cfg_q.polar_min <= azh_pkg::POLAR_MIN_RST;
			cfg_q.polar_max <= azh_pkg::POLAR_MAX_RST;
			cfg_q.azimuth_origin <= azh_pkg::ORIGIN_RST;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					azh_pkg::REG_POLAR_MIN: cfg_q.polar_min <= cfg_wdata;
					azh_pkg::REG_POLAR_MAX: cfg_q.polar_max <= cfg_wdata;
					azh_pkg::REG_AZIMUTH_ORIGIN: begin
						cfg_q.azimuth_origin <= cfg_wdata[azh_pkg::ANG_W-1:0];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q <= opcode;
			mask_q <= pattern_mask;
			rh_q <= read_histogram;
			rb_q <= read_bin;
			rd_ok_q <= (32'(read_histogram) <= NUM_PATTERNS) && (32'(read_bin) < NUM_BINS);
			addr_q <= AW'(read_bin);
		end else if (state_q == azh_pkg::ST_BIN && bin_done) begin
			pass_q <= bin_pass;
			wrap_q <= bin_wrap;
			delta_q <= bin_delta;
			addr_q <= bin_idx;
		end
	end

	azh_binner #(
		.NUM_BINS(NUM_BINS)
	) u_binner (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (bin_start),
		.event_ok        (event_ok),
		.polar_angle     (polar_angle),
		.azimuth_angle   (azimuth_angle),
		.cfg             (cfg_q),
		.done            (bin_done),
		.pass            (bin_pass),
		.wrapped_azimuth (bin_wrap),
		.bin             (bin_idx),
		.delta           (bin_delta)
	);

	for (genvar h = 0; h < NUM_HISTS; h++) begin : g_bank
		logic [EW-1:0] rd_raw;

		if (h == 0) begin : g_all
			assign bank_en[h] = 1'b1;
		end else if (h <= azh_pkg::MASK_W) begin : g_pat
			assign bank_en[h] = mask_q[h-1];
		end else begin : g_none
			assign bank_en[h] = 1'b0;
		end

		azh_ram #(
			.WIDTH(EW),
			.DEPTH(NUM_BINS)
		) u_ram (
			.clk   (clk),
			.we    (clearing || (commit && op_q == azh_pkg::OP_EVENT && pass_q && bank_en[h])),
			.waddr (waddr),
			.wdata (clearing ? '0 : upd[h]),
			.re    (rd_en),
			.raddr (addr_q),
			.rdata (rd_raw)
		);

		assign rdata[h] = rd_raw;

		azh_acc u_acc (
			.cur   (rdata[h]),
			.delta (delta_q),
			.nxt   (upd[h])
		);
	end

	always_comb begin
		sel = '0;
		for (int h = 0; h < NUM_HISTS; h++) begin
			if (rd_ok_q && 32'(h) == 32'(rh_q)) begin
				sel = rdata[h];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (op_q == azh_pkg::OP_READ) begin
				accepted_q <= 1'b0;
				wrap_out_q <= '0;
				bin_index_q <= rb_q;
				bin_count_q <= sel.count;
				offset_sum_q <= sel.sum;
			end else if (pass_q) begin
				accepted_q <= 1'b1;
				wrap_out_q <= wrap_q;
				bin_index_q <= azh_pkg::RBIN_W'(addr_q);
				bin_count_q <= upd[0].count;
				offset_sum_q <= upd[0].sum;
			end else begin
				accepted_q <= 1'b0;
				wrap_out_q <= '0;
				bin_index_q <= '0;
				bin_count_q <= '0;
				offset_sum_q <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = accepted_q;
	assign wrapped_azimuth = wrap_out_q;
	assign bin_index       = bin_index_q;
	assign bin_count       = bin_count_q;
	assign offset_sum      = offset_sum_q;

	`AZH_ASSERT_IMPL(a_done_in_bin, clk, arst_n, bin_done, state_q == azh_pkg::ST_BIN, "binner result outside bin wait")
	`AZH_ASSERT_IMPL(a_hit_counted, clk, arst_n, out_valid_q && accepted_q, bin_count_q != 32'd0, "accepted event shows zero count")
	`AZH_ASSERT_IMPL(a_wrap_range, clk, arst_n, out_valid_q && accepted_q, wrap_out_q >= -17'sd46080, "wrapped azimuth below half turn")
	`AZH_ASSERT_NEXT(a_clear_once, clk, arst_n, state_q != azh_pkg::ST_CLEAR, state_q != azh_pkg::ST_CLEAR, "clearing pass restarted")

endmodule

[sim/tb.sv]
// Testbench for azimuth_histogram_with_bin_offsets: a directed table, then random event and
// bin-read streams over several cut and origin settings, checked against an in-bench predictor.
// Depends on azh_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;

	localparam int NUM_BINS     = 64;
	localparam int NUM_PATTERNS = 8;
	localparam int NUM_HISTS    = NUM_PATTERNS + 1;
	localparam int FULL_TURN    = azh_pkg::FULL_TURN;
	localparam int HALF_TURN    = azh_pkg::HALF_TURN;
	localparam int ANG_W        = azh_pkg::ANG_W;
	localparam int MASK_W       = azh_pkg::MASK_W;
	localparam int HIST_W       = azh_pkg::HIST_W;
	localparam int RBIN_W       = azh_pkg::RBIN_W;
	localparam int COUNT_W      = azh_pkg::COUNT_W;
	localparam int SUM_W        = azh_pkg::SUM_W;
	localparam int CFG_IDX_W    = azh_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W   = azh_pkg::CFG_DATA_W;
	localparam int BIN_WIDTH    = FULL_TURN / NUM_BINS;
	localparam int DIR_ROWS     = 21;
	localparam int MAX_REPORTS  = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic                    op;
		logic                    ok;
		logic signed [ANG_W-1:0] polar;
		logic signed [ANG_W-1:0] azim;
		logic [MASK_W-1:0]       mask;
		logic [HIST_W-1:0]       hist;
		logic [RBIN_W-1:0]       rbin;
	} cmd_t;

	typedef struct packed {
		logic                    accepted;
		logic signed [ANG_W-1:0] wrapped;
		logic [RBIN_W-1:0]       bin_idx;
		logic [COUNT_W-1:0]      cnt;
		logic signed [SUM_W-1:0] ofs_sum;
	} hist_result_t;

	// zero_res: result is all zero (bin_index echoes read_bin on reads)
	typedef struct packed {
		cmd_t cmd;
		logic zero_res;
	} dir_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_wdata;
	logic                        in_valid;
	logic                        in_ready;
	logic                        opcode;
	logic                        event_ok;
	logic signed [ANG_W-1:0]     polar_angle;
	logic signed [ANG_W-1:0]     azimuth_angle;
	logic [MASK_W-1:0]           pattern_mask;
	logic [HIST_W-1:0]           read_histogram;
	logic [RBIN_W-1:0]           read_bin;
	logic                        out_valid;
	logic                        out_ready;
	logic                        accepted;
	logic signed [ANG_W-1:0]     wrapped_azimuth;
	logic [RBIN_W-1:0]           bin_index;
	logic [COUNT_W-1:0]          bin_count;
	logic signed [SUM_W-1:0]     offset_sum;

	logic [COUNT_W-1:0] bank_cnt [NUM_HISTS*NUM_BINS];
	longint             bank_sum [NUM_HISTS*NUM_BINS];
	int                 cut_lo;
	int                 cut_hi;
	int                 az_origin;
	logic [RBIN_W-1:0]  last_bin;
	bit                 sender_burst;
	hist_result_t       awaited_bins [$];
	int                 mismatches;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{azh_pkg::OP_READ,  1'b1, 17'sd0,      17'sd0,      8'h00, 4'd0,  6'd0},  1'b1},
		'{'{azh_pkg::OP_READ,  1'b0, 17'sd46080,  -17'sd46080, 8'hff, 4'd8,  6'd63}, 1'b1},
		'{'{azh_pkg::OP_READ,  1'b1, -17'sd46080, 17'sd46080,  8'h00, 4'd15, 6'd5},  1'b1},
		'{'{azh_pkg::OP_EVENT, 1'b0, 17'sd0,      17'sd0,      8'hff, 4'd0,  6'd0},  1'b1},
		'{'{azh_pkg::OP_EVENT, 1'b1, -17'sd257,   17'sd100,    8'hff, 4'd3,  6'd7},  1'b1},
		'{'{azh_pkg::OP_EVENT, 1'b1, -17'sd46080, 17'sd0,      8'h01, 4'd0,  6'd0},  1'b1},
		'{'{azh_pkg::OP_EVENT, 1'b1, -17'sd256,   -17'sd46080, 8'hff, 4'd0,  6'd0},  1'b0},
		'{'{azh_pkg::OP_EVENT, 1'b1, 17'sd46080,  17'sd46080,  8'h01, 4'd0,  6'd0},  1'b0},
		'{'{azh_pkg::OP_EVENT, 1'b1, 17'sd0,      17'sd0,      8'h80, 4'd0,  6'd0},  1'b0},
		'{'{azh_pkg::OP_EVENT, 1'b1, 17'sd100,    17'sd46079,  8'haa, 4'd0,  6'd0},  1'b0},
		'{'{azh_pkg::OP_EVENT, 1'b1, 17'sd100,    -17'sd1,     8'h55, 4'd0,  6'd0},  1'b0},
		'{'{azh_pkg::OP_EVENT, 1'b1, 17'sd100,    17'sd720,    8'h00, 4'd0,  6'd0},  1'b0},
		'{'{azh_pkg::OP_EVENT, 1'b1, 17'sd100,    17'sd1439,   8'h0f, 4'd15, 6'd63}, 1'b0},
		'{'{azh_pkg::OP_EVENT, 1'b1, 17'sd100,    17'sd1440,   8'hf0, 4'd0,  6'd0},  1'b0},
		'{'{azh_pkg::OP_READ,  1'b0, 17'sd0,      17'sd0,      8'h00, 4'd0,  6'd0},  1'b0},
		'{'{azh_pkg::OP_READ,  1'b1, 17'sd0,      17'sd0,      8'hff, 4'd1,  6'd0},  1'b0},
		'{'{azh_pkg::OP_READ,  1'b0, 17'sd0,      17'sd0,      8'h00, 4'd8,  6'd0},  1'b0},
		'{'{azh_pkg::OP_READ,  1'b0, 17'sd0,      17'sd0,      8'h00, 4'd9,  6'd0},  1'b1},
		'{'{azh_pkg::OP_READ,  1'b0, 17'sd0,      17'sd0,      8'h00, 4'd2,  6'd32}, 1'b0},
		'{'{azh_pkg::OP_READ,  1'b0, 17'sd0,      17'sd0,      8'h00, 4'd0,  6'd63}, 1'b0},
		'{'{azh_pkg::OP_READ,  1'b0, 17'sd0,      17'sd0,      8'h00, 4'd8,  6'd63}, 1'b0}
	};

	azimuth_histogram_with_bin_offsets #(
		.NUM_BINS     (NUM_BINS),
		.NUM_PATTERNS (NUM_PATTERNS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.event_ok        (event_ok),
		.polar_angle     (polar_angle),
		.azimuth_angle   (azimuth_angle),
		.pattern_mask    (pattern_mask),
		.read_histogram  (read_histogram),
		.read_bin        (read_bin),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.accepted        (accepted),
		.wrapped_azimuth (wrapped_azimuth),
		.bin_index       (bin_index),
		.bin_count       (bin_count),
		.offset_sum      (offset_sum)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// histogram model

	function automatic void clear_banks();
		foreach (bank_cnt[i]) begin
			bank_cnt[i] = '0;
			bank_sum[i] = 0;
		end
		cut_lo    = int'(azh_pkg::POLAR_MIN_RST);
		cut_hi    = int'(azh_pkg::POLAR_MAX_RST);
		az_origin = int'(azh_pkg::ORIGIN_RST);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
		azh_pkg::REG_POLAR_MIN:      cut_lo = int'($signed(data));
		azh_pkg::REG_POLAR_MAX:      cut_hi = int'($signed(data));
		azh_pkg::REG_AZIMUTH_ORIGIN: az_origin = int'($signed(data[ANG_W-1:0]));
		default: ;
		endcase
	endfunction

	function automatic void add_hit(int idx, longint delta);
		longint s;
		if (bank_cnt[idx] != '1)
			bank_cnt[idx] = bank_cnt[idx] + 1;
		s = bank_sum[idx] + delta;
		if (s > longint'(azh_pkg::SUM_MAX))
			s = longint'(azh_pkg::SUM_MAX);
		if (s < longint'(azh_pkg::SUM_MIN))
			s = longint'(azh_pkg::SUM_MIN);
		bank_sum[idx] = s;
	endfunction

	function automatic hist_result_t histogram_step(cmd_t c);
		hist_result_t r;
		int pol;
		int az;
		int m;
		int b;
		int idx;
		int num;
		longint delta;
		r = '0;
		if (c.op == azh_pkg::OP_READ) begin
			r.bin_idx = c.rbin;
			if (int'(c.hist) <= NUM_PATTERNS && int'(c.rbin) < NUM_BINS) begin
				idx = int'(c.hist) * NUM_BINS + int'(c.rbin);
				r.cnt = bank_cnt[idx];
				r.ofs_sum = bank_sum[idx][SUM_W-1:0];
			end
			return r;
		end
		pol = int'(c.polar);
		az = int'(c.azim);
		if (!c.ok || pol < cut_lo || pol > cut_hi)
			return r;
		m = (az - az_origin + HALF_TURN) % FULL_TURN;
		if (m < 0)
			m += FULL_TURN;
		b = (m * NUM_BINS) / FULL_TURN;
		num = m * 2 * NUM_BINS - (2 * b + 1) * FULL_TURN;
		delta = longint'(num + NUM_BINS) >>> $clog2(2 * NUM_BINS);
		add_hit(b, delta);
		for (int i = 0; i < MASK_W && i < NUM_PATTERNS; i++) begin
			if (c.mask[i])
				add_hit((i + 1) * NUM_BINS + b, delta);
		end
		r.accepted = 1'b1;
		r.wrapped = ANG_W'(m - HALF_TURN);
		r.bin_idx = RBIN_W'(b);
		r.cnt = bank_cnt[b];
		r.ofs_sum = bank_sum[b][SUM_W-1:0];
		return r;
	endfunction

	// stimulus

	function automatic logic signed [ANG_W-1:0] pick_azimuth();
		int v;
		int nudge;
		case ($urandom_range(9))
		0, 1: begin
			case ($urandom_range(3))
			0: nudge = -1;
			1: nudge = 0;
			2: nudge = BIN_WIDTH / 2 - 1;
			default: nudge = BIN_WIDTH - 1;
			endcase
			v = az_origin - HALF_TURN + BIN_WIDTH * int'($urandom_range(NUM_BINS - 1)) + nudge;
			while (v < -HALF_TURN)
				v += FULL_TURN;
			while (v > HALF_TURN)
				v -= FULL_TURN;
		end
		2: v = $urandom_range(1) ? -HALF_TURN : HALF_TURN;
		default: v = rand_between(-HALF_TURN, HALF_TURN);
		endcase
		return ANG_W'(v);
	endfunction

	function automatic logic [MASK_W-1:0] pick_mask();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return '0;
		if (r < 35)
			return '1;
		return MASK_W'($urandom_range(255));
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int kind;
		int lo;
		int hi;
		int edge_hi;
		int edge_lo;
		lo = (cut_lo > -HALF_TURN) ? cut_lo : -HALF_TURN;
		hi = (cut_hi < HALF_TURN) ? cut_hi : HALF_TURN;
		kind = $urandom_range(99);
		c.op = azh_pkg::OP_EVENT;
		c.ok = 1'b1;
		c.polar = ANG_W'(rand_between(-HALF_TURN, HALF_TURN));
		c.azim = pick_azimuth();
		c.mask = pick_mask();
		c.hist = HIST_W'($urandom_range(15));
		c.rbin = RBIN_W'($urandom_range(63));
		if (kind < 55) begin
			if (lo <= hi) begin
				if ($urandom_range(9) == 0)
					c.polar = ANG_W'($urandom_range(1) ? lo : hi);
				else
					c.polar = ANG_W'(rand_between(lo, hi));
			end
		end else if (kind < 67) begin
			case ($urandom_range(2))
			0: c.ok = 1'b0;
			1: begin
				if (cut_lo > -HALF_TURN) begin
					edge_hi = (cut_lo - 1 < HALF_TURN) ? cut_lo - 1 : HALF_TURN;
					c.polar = ANG_W'($urandom_range(1) ? edge_hi
						: rand_between(-HALF_TURN, edge_hi));
				end else begin
					c.ok = 1'b0;
				end
			end
			default: begin
				if (cut_hi < HALF_TURN) begin
					edge_lo = (cut_hi + 1 > -HALF_TURN) ? cut_hi + 1 : -HALF_TURN;
					c.polar = ANG_W'($urandom_range(1) ? edge_lo
						: rand_between(edge_lo, HALF_TURN));
				end else begin
					c.ok = 1'b0;
				end
			end
			endcase
		end else begin
			c.op = azh_pkg::OP_READ;
			c.ok = 1'($urandom_range(1));
			if ($urandom_range(9) == 0)
				c.hist = HIST_W'($urandom_range(15, NUM_PATTERNS + 1));
			else
				c.hist = HIST_W'($urandom_range(NUM_PATTERNS));
			if ($urandom_range(1))
				c.rbin = last_bin;
		end
		return c;
	endfunction

	function automatic int sender_gap();
		int r;
		if (sender_burst)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic send_cmd(cmd_t c, int gap, bit zero_res);
		hist_result_t want;
		hist_result_t predicted;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		opcode         = c.op;
		event_ok       = c.ok;
		polar_angle    = c.polar;
		azimuth_angle  = c.azim;
		pattern_mask   = c.mask;
		read_histogram = c.hist;
		read_bin       = c.rbin;
		in_valid       = 1'b1;
		do @(posedge clk); while (!in_ready);
		predicted = histogram_step(c);
		if (zero_res) begin
			want = '0;
			if (c.op == azh_pkg::OP_READ)
				want.bin_idx = c.rbin;
		end else begin
			want = predicted;
		end
		if (predicted.accepted)
			last_bin = predicted.bin_idx;
		awaited_bins.push_back(want);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (awaited_bins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		apply_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_phase(int lo, int hi, int origin, int n);
		logic [CFG_DATA_W-1:0] w;
		drain();
		write_reg(azh_pkg::REG_POLAR_MIN, CFG_DATA_W'(lo));
		write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(2**CFG_DATA_W - 1)));
		write_reg(azh_pkg::REG_POLAR_MAX, CFG_DATA_W'(hi));
		w = CFG_DATA_W'(origin);
		w[CFG_DATA_W-1] = 1'($urandom_range(1));
		write_reg(azh_pkg::REG_AZIMUTH_ORIGIN, w);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0)
				sender_burst = ($urandom_range(3) == 0);
			if ($urandom_range(49) == 0)
				drain();
			send_cmd(random_cmd(), sender_gap(), 1'b0);
		end
	endtask

	function automatic int rand_cut();
		return rand_between(-50000, 50000);
	endfunction

	// result checking

	task automatic note_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %s: expected %0h, got %0h at %0t", what, want_v, got_v, $time);
	endtask

	task automatic check_result(hist_result_t got);
		hist_result_t want;
		if (awaited_bins.size() == 0) begin
			note_mismatch("result with none awaited", '0, 64'(got.bin_idx));
			return;
		end
		want = awaited_bins.pop_front();
		if (got.accepted !== want.accepted)
			note_mismatch("accepted", 64'(want.accepted), 64'(got.accepted));
		if (got.wrapped !== want.wrapped)
			note_mismatch("wrapped_azimuth", 64'(want.wrapped), 64'(got.wrapped));
		if (got.bin_idx !== want.bin_idx)
			note_mismatch("bin_index", 64'(want.bin_idx), 64'(got.bin_idx));
		if (got.cnt !== want.cnt)
			note_mismatch("bin_count", 64'(want.cnt), 64'(got.cnt));
		if (got.ofs_sum !== want.ofs_sum)
			note_mismatch("offset_sum", 64'(want.ofs_sum), 64'(got.ofs_sum));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result('{accepted, wrapped_azimuth, bin_index, bin_count, offset_sum});
	end

	// receiver stalls: mostly short, a few long, with calm stretches
	initial begin
		int stall;
		int calm;
		int r;
		stall = 0;
		calm = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				r = $urandom_range(99);
				if (calm > 0)
					calm--;
				else if (r < 2)
					calm = $urandom_range(300, 100);
				else if (r < 20)
					stall = $urandom_range(3, 1);
				else if (r < 24)
					stall = $urandom_range(15, 4);
				else if (r == 24)
					stall = $urandom_range(80, 30);
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		opcode         = azh_pkg::OP_EVENT;
		event_ok       = 1'b0;
		polar_angle    = '0;
		azimuth_angle  = '0;
		pattern_mask   = '0;
		read_histogram = '0;
		read_bin       = '0;
		mismatches     = 0;
		last_bin       = '0;
		sender_burst   = 1'b0;
		clear_banks();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].cmd, sender_gap(), dir_rows[i].zero_res);

		run_phase(-92160, 92160, -HALF_TURN, 150);
		run_phase(rand_cut(), rand_cut(), rand_between(-HALF_TURN, HALF_TURN), 150);
		run_phase(92160, -92160, HALF_TURN, 100);
		run_phase(0, 0, rand_between(-HALF_TURN, HALF_TURN), 150);
		begin
			int a;
			int b;
			a = rand_cut();
			b = rand_cut();
			run_phase((a < b) ? a : b, (a < b) ? b : a, rand_between(-HALF_TURN, HALF_TURN), 200);
			a = rand_cut();
			b = rand_cut();
			run_phase((a < b) ? a : b, (a < b) ? b : a, rand_between(-HALF_TURN, HALF_TURN), 150);
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/azh_pkg.sv
src/azh_ram.sv
src/azh_acc.sv
src/azh_binner.sv
src/azimuth_histogram_with_bin_offsets.sv
sim/tb.sv
